// File: hw/rtl/bounded_double_ended_queue_unit_macros.svh
// Assertion macros for the double-ended queue unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BDQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define BDQ_ASSERT(lbl, prop, msg)
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/bdq_pkg.sv
// Package for the double-ended queue unit: sizes, codes, item types, ring helper.
// No dependencies.
package bdq_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WORD_W   = 32;
   localparam int OP_W     = 3;
   localparam int POS_W    = 6;
   localparam int STAT_W   = 2;
   localparam int FILL_W   = 7;

   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ       = 3'd4;
   localparam logic [OP_W-1:0] OP_WRITE      = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BEYOND = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [WORD_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [WORD_W-1:0] read_data;
      logic [FILL_W-1:0]        fill_count;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic              valid;
      logic              rd_hit;
      logic [STAT_W-1:0] status;
      logic [FILL_W-1:0] fill_count;
   } rsp_meta_type;

   function automatic logic [ADDR_W-1:0] ring_slot(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] offs);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= (ADDR_W+1)'(CAPACITY)) begin
         sum = sum - (ADDR_W+1)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// File: hw/rtl/bdq_word_ram.sv
// Single-port synchronous word memory, registered read data.
// Generic; no package dependencies.
module bdq_word_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/bdq_ctrl.sv
// Queue control: front pointer and count, operation decode, memory commands.
// Depends on bdq_pkg and the assertion macro header.
`include "bounded_double_ended_queue_unit_macros.svh"

module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_type      req,
   output mem_cmd_type  mem_cmd,
   output rsp_meta_type meta
);

   logic [ADDR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   rsp_meta_type      meta_ff, meta_in;

   logic              is_full;
   logic              is_empty;
   logic              pos_beyond;
   logic [ADDR_W-1:0] front_dec;
   logic [ADDR_W-1:0] front_inc;

   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign pos_beyond = ((CNT_W+POS_W)'(req.position) >= (CNT_W+POS_W)'(count_ff));
   assign front_dec  = (front_ff == '0) ? ADDR_W'(CAPACITY - 1) : front_ff - 1'b1;
   assign front_inc  = (front_ff == ADDR_W'(CAPACITY - 1)) ? '0 : front_ff + 1'b1;

   always_comb begin
      front_in       = front_ff;
      count_in       = count_ff;
      mem_cmd.we     = 1'b0;
      mem_cmd.re     = 1'b0;
      mem_cmd.addr   = ring_slot(front_ff, ADDR_W'(req.position));
      mem_cmd.wdata  = req.value;
      meta_in.valid  = accept;
      meta_in.rd_hit = 1'b0;
      meta_in.status = ST_OK;
      if (accept) begin
         case (req.operation)
            OP_PUSH_BACK: begin
               if (is_full) begin
                  meta_in.status = ST_FULL;
               end else begin
                  mem_cmd.we   = 1'b1;
                  mem_cmd.addr = ring_slot(front_ff, ADDR_W'(count_ff));
                  count_in     = count_ff + 1'b1;
               end
            end
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  meta_in.status = ST_FULL;
               end else begin
                  mem_cmd.we   = 1'b1;
                  mem_cmd.addr = front_dec;
                  front_in     = front_dec;
                  count_in     = count_ff + 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (is_empty) begin
                  meta_in.status = ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (is_empty) begin
                  meta_in.status = ST_EMPTY;
               end else begin
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_READ: begin
               if (pos_beyond) begin
                  meta_in.status = ST_BEYOND;
               end else begin
                  mem_cmd.re     = 1'b1;
                  meta_in.rd_hit = 1'b1;
               end
            end
            OP_WRITE: begin
               if (pos_beyond) begin
                  meta_in.status = ST_BEYOND;
               end else begin
                  mem_cmd.we = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      meta_in.fill_count = FILL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         meta_ff  <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         meta_ff  <= meta_in;
      end
   end

   assign meta = meta_ff;

   `BDQ_ASSERT(a_count_bound, (count_ff <= CNT_W'(CAPACITY)), "count beyond capacity")
   `BDQ_ASSERT_ALWAYS(a_no_rw_clash, !(mem_cmd.we && mem_cmd.re), "read and write together")
   `BDQ_ASSERT(a_strobe_follows, (accept |=> meta_ff.valid), "missing result strobe")
   `BDQ_ASSERT(a_no_spurious, (!accept |=> !meta_ff.valid), "result without item")
   `BDQ_ASSERT(a_push_grows, (accept && !is_full && req.operation == OP_PUSH_BACK |=> count_ff == $past(count_ff) + 1'b1), "push back did not grow")

endmodule

// File: hw/rtl/bounded_double_ended_queue_unit.sv
// Bounded double-ended queue unit, top level. Uses bdq_pkg, bdq_ctrl, bdq_word_ram.
// The result strobe comes in the cycle after the item is accepted.
// Throughput: one item per cycle; busy stays low, the ring pointer and count
// update in the accept cycle and the word memory read data lands with the result strobe.
// Reset clears front pointer, count and the result strobe; the store is not cleared.
module bounded_double_ended_queue_unit
   import bdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   logic              accept;
   mem_cmd_type       mem_cmd;
   rsp_meta_type      meta;
   logic [WORD_W-1:0] ram_rdata;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   bdq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_item),
      .mem_cmd (mem_cmd),
      .meta    (meta)
   );

   bdq_word_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (WORD_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_cmd.we),
      .re    (mem_cmd.re),
      .addr  (mem_cmd.addr),
      .wdata (mem_cmd.wdata),
      .rdata (ram_rdata)
   );

   assign rsp_strobe          = meta.valid;
   assign rsp_item.status     = meta.status;
   assign rsp_item.read_data  = meta.rd_hit ? ram_rdata : '0;
   assign rsp_item.fill_count = meta.fill_count;

endmodule

// File: tb/bdq_result_checker.sv
// Result checker for the double-ended queue unit: watches both channels, predicts each result.
// Depends on bdq_pkg for the item types, sizes and operation and status codes.
module bdq_result_checker
   import bdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      fault_count,
   output int      waiting_count,
   output int      checked_count,
   output int      full_count,
   output int      empty_count,
   output int      beyond_count
);

   logic signed [WORD_W-1:0] ring_words [CAPACITY];
   int unsigned              ring_head;
   int unsigned              ring_fill;
   rsp_type                  awaited_results [$];
   rsp_type                  due;

   function automatic rsp_type apply_deque_op(input req_type item);
      rsp_type res;
      res = '0;
      case (item.operation)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (ring_fill >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (item.operation == OP_PUSH_BACK) begin
               ring_words[(ring_head + ring_fill) % CAPACITY] = item.value;
               ring_fill++;
            end else begin
               ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
               ring_words[ring_head] = item.value;
               ring_fill++;
            end
         end
         OP_POP_BACK, OP_POP_FRONT: begin
            if (ring_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               if (item.operation == OP_POP_FRONT) begin
                  ring_head = (ring_head + 1) % CAPACITY;
               end
               ring_fill--;
            end
         end
         OP_READ, OP_WRITE: begin
            if (item.position >= ring_fill) begin
               res.status = ST_BEYOND;
            end else if (item.operation == OP_READ) begin
               res.read_data = ring_words[(ring_head + item.position) % CAPACITY];
            end else begin
               ring_words[(ring_head + item.position) % CAPACITY] = item.value;
            end
         end
         default: begin
         end
      endcase
      res.fill_count = FILL_W'(ring_fill);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ring_head = 0;
         ring_fill = 0;
         awaited_results.delete();
         waiting_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("[%0t] unexpected result: status %0d data %0d fill %0d", $realtime,
                           rsp_item.status, rsp_item.read_data, rsp_item.fill_count);
               end
            end else begin
               due = awaited_results[0];
               awaited_results.delete(0);
               checked_count++;
               if (rsp_item.status !== due.status || rsp_item.read_data !== due.read_data ||
                   rsp_item.fill_count !== due.fill_count) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("[%0t] mismatch: status %0d/%0d data %0d/%0d fill %0d/%0d (exp/got)",
                              $realtime, due.status, rsp_item.status, due.read_data,
                              rsp_item.read_data, due.fill_count, rsp_item.fill_count);
                  end
               end
            end
         end
         if (start && !busy) begin
            due = apply_deque_op(req_item);
            case (due.status)
               ST_FULL:   full_count++;
               ST_EMPTY:  empty_count++;
               ST_BEYOND: beyond_count++;
               default: begin
               end
            endcase
            awaited_results.insert(awaited_results.size(), due);
         end
         waiting_count = awaited_results.size();
      end
   end

endmodule

// File: tb/bounded_double_ended_queue_unit_tb.sv
// Testbench top for the double-ended queue unit: clock, reset, item stimulus and verdict.
// Depends on bdq_pkg, bounded_double_ended_queue_unit and bdq_result_checker.
module bounded_double_ended_queue_unit_tb;
   import bdq_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int fault_count;
   int waiting_count;
   int checked_count;
   int full_count;
   int empty_count;
   int beyond_count;

   int burst_left = 0;
   int items_sent = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   bounded_double_ended_queue_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   bdq_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .fault_count   (fault_count),
      .waiting_count (waiting_count),
      .checked_count (checked_count),
      .full_count    (full_count),
      .empty_count   (empty_count),
      .beyond_count  (beyond_count)
   );

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_pos();
      if ($urandom_range(0, 2) == 0) begin
         return POS_W'($urandom_range(0, 63));
      end
      return POS_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [OP_W-1:0] pick_push();
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
   endfunction

   function automatic logic [OP_W-1:0] pick_pop();
      return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input int push_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         return $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      end
      if (r < 38) begin
         return $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      end
      return ($urandom_range(0, 99) < push_pct) ? pick_push() : pick_pop();
   endfunction

   // Drives one item, waits for it to be taken, then at the end of a burst may idle with junk on the item.
   task automatic issue(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] val,
                        input logic [POS_W-1:0] pos);
      req_type item;
      req_type junk;
      int      gap;
      item.operation = op;
      item.value     = val;
      item.position  = pos;
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      items_sent++;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            junk.operation = OP_W'($urandom);
            junk.value     = WORD_W'($urandom);
            junk.position  = POS_W'($urandom);
            start    <= 1'b0;
            req_item <= junk;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   initial begin
      int kind;
      int seg_len;
      int push_pct;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pops, out-of-range access, spare codes, extremes of value and position
      issue(OP_POP_BACK, pick_word(), pick_pos());
      issue(OP_POP_FRONT, pick_word(), pick_pos());
      issue(OP_READ, '0, 6'd0);
      issue(OP_WRITE, 32'sh1234_5678, 6'd63);
      issue(OP_SPARE_LO, 32'sh7fff_ffff, 6'd63);
      issue(OP_SPARE_HI, 32'sh8000_0000, 6'd0);
      issue(OP_PUSH_BACK, 32'sh7fff_ffff, 6'd63);
      issue(OP_PUSH_FRONT, 32'sh8000_0000, 6'd0);
      issue(OP_PUSH_BACK, '0, 6'd21);
      issue(OP_PUSH_FRONT, -32'sd1, 6'd42);
      issue(OP_READ, '0, 6'd0);
      issue(OP_READ, '0, 6'd3);
      issue(OP_READ, '0, 6'd4);
      issue(OP_WRITE, 32'sh5555_5555, 6'd2);
      issue(OP_READ, 32'shaaaa_aaaa, 6'd2);
      issue(OP_POP_FRONT, '0, 6'd0);
      issue(OP_POP_BACK, '0, 6'd0);
      issue(OP_READ, '0, 6'd0);
      issue(OP_READ, '0, 6'd1);
      issue(OP_POP_BACK, '0, 6'd0);
      issue(OP_POP_FRONT, '0, 6'd0);
      issue(OP_POP_FRONT, '0, 6'd0);
      issue(OP_PUSH_FRONT, 32'sd1, 6'd0);
      issue(OP_READ, '0, 6'd63);
      issue(OP_POP_BACK, '0, 6'd0);

      // random: fill to capacity, access the full ring, drain, then mixed segments
      repeat (72) issue(pick_push(), pick_word(), pick_pos());
      repeat (40) issue($urandom_range(0, 1) ? OP_READ : OP_WRITE, pick_word(),
                        POS_W'($urandom_range(0, 63)));
      repeat (72) issue(pick_pop(), pick_word(), pick_pos());
      while (items_sent < 750) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat (72) issue(pick_push(), pick_word(), pick_pos());
         end else if (kind == 1) begin
            repeat (72) issue(pick_pop(), pick_word(), pick_pos());
         end else begin
            seg_len  = $urandom_range(10, 40);
            push_pct = 25 + 25 * $urandom_range(0, 2);
            repeat (seg_len) issue(pick_op(push_pct), pick_word(), pick_pos());
         end
      end

      start <= 1'b0;
      while (waiting_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d items, checked %0d results.", items_sent, checked_count);
      $display("Push on full %0d, pop on empty %0d, access beyond count %0d.",
               full_count, empty_count, beyond_count);
      if (fault_count == 0 && waiting_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #(12 * 200000);
      $display("Timeout waiting for the run to finish.");
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_word_ram.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bounded_double_ended_queue_unit.sv
tb/bdq_result_checker.sv
tb/bounded_double_ended_queue_unit_tb.sv
